// ===== rtl/core/bef_pkg.sv =====
// bef_pkg: shared types, register indexes and microcode rom for the bandpass
// envelope follower core
// no dependencies
package bef_pkg;

  // default widths of the audio sample and of the filter coefficients
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  // configuration port
  localparam int CFG_IDX_W = 3;

  // rate register reset values, Q0.16 (about 0.05 and 0.03)
  localparam logic [15:0] ATTACK_RST  = 16'd3277;
  localparam logic [15:0] RELEASE_RST = 16'd1966;

  // result beat layout
  localparam int OUT_TDATA_W = 64;

  // microcode step counter
  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_ZERO = 3'd0,
    REG_FEED_TWO  = 3'd1,
    REG_BACK_ONE  = 3'd2,
    REG_BACK_TWO  = 3'd3,
    REG_ATTACK    = 3'd4,
    REG_RELEASE   = 3'd5
  } cfg_idx_e;

  // datapath operation of one step
  typedef enum logic [1:0] {
    OP_NOP,
    OP_MAC,
    OP_SAT,
    OP_ENV
  } op_e;

  // multiplier data operand
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_X,
    SRC_X2,
    SRC_YNEG
  } src_e;

  // multiplier coefficient operand
  typedef enum logic [1:0] {
    COEF_FF0,
    COEF_FF2,
    COEF_FB1,
    COEF_FB2
  } coef_e;

  // handshake a step waits on before it may proceed
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  // one control word
  typedef struct packed {
    op_e   op;
    src_e  src;    // for the feedback taps: SRC_YNEG picks y[-1] or y[-2] by coef
    coef_e coef;
    logic  hi;     // upper coefficient half, weighted by 2^16
    logic  clr;    // start a new sum
    wait_e wt;
    step_t nxt;
  } uword_t;

  // program: eight multiply-accumulate steps over coefficient halves,
  // then saturate, then envelope update and result write
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      4'd0:    w = '{OP_MAC, SRC_IN,   COEF_FF0, 1'b0, 1'b1, WAIT_IN,   4'd1};
      4'd1:    w = '{OP_MAC, SRC_X,    COEF_FF0, 1'b1, 1'b0, WAIT_NONE, 4'd2};
      4'd2:    w = '{OP_MAC, SRC_X2,   COEF_FF2, 1'b0, 1'b0, WAIT_NONE, 4'd3};
      4'd3:    w = '{OP_MAC, SRC_X2,   COEF_FF2, 1'b1, 1'b0, WAIT_NONE, 4'd4};
      4'd4:    w = '{OP_MAC, SRC_YNEG, COEF_FB1, 1'b0, 1'b0, WAIT_NONE, 4'd5};
      4'd5:    w = '{OP_MAC, SRC_YNEG, COEF_FB1, 1'b1, 1'b0, WAIT_NONE, 4'd6};
      4'd6:    w = '{OP_MAC, SRC_YNEG, COEF_FB2, 1'b0, 1'b0, WAIT_NONE, 4'd7};
      4'd7:    w = '{OP_MAC, SRC_YNEG, COEF_FB2, 1'b1, 1'b0, WAIT_NONE, 4'd8};
      4'd8:    w = '{OP_SAT, SRC_X,    COEF_FF0, 1'b0, 1'b0, WAIT_NONE, 4'd9};
      4'd9:    w = '{OP_ENV, SRC_X,    COEF_FF0, 1'b0, 1'b0, WAIT_OUT,  4'd0};
      default: w = '{OP_NOP, SRC_X,    COEF_FF0, 1'b0, 1'b0, WAIT_NONE, 4'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/bandpass_envelope_follower_core.sv =====
// bandpass_envelope_follower_core: biquad bandpass plus envelope tracker,
// run by a microcoded sequencer over one shared multiplier
// depends on bef_pkg
//
// Each input beat is one signed audio sample (Q1.(SAMPLE_WIDTH-1)); each result
// beat carries the bandpass output (Q8.24, saturated to 32 bits) and the updated
// envelope level (Q8.24), with tuser flagging that the filter sum was clipped.
// Each sample runs through the microcode one step at a time: the accepting
// step and seven more multiply-accumulate steps, one per coefficient half through
// the single shared multiplier, then one saturation step and one envelope step.
// The envelope step writes the result into the output register, and the next
// sample is accepted only after that step, so the core takes no new sample while
// one is still in flight; if the previous result is still not taken, the
// envelope step waits for it. Coefficients and rates must be written through the
// cfg port only while no sample is in flight; the core itself does not enforce this.
module bandpass_envelope_follower_core #(
  parameter int SAMPLE_WIDTH = bef_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bef_pkg::COEF_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [bef_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]                  cfg_data_i,
  // sample input
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
  // result output
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [bef_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // filtered, envelope, zero pad
  output logic                                   m_axis_tuser   // saturated
);

  localparam int COEF_FRAC = COEF_WIDTH - 4;
  localparam int HI_W      = COEF_WIDTH - 16;
  localparam int MUL_B     = (HI_W > 17) ? HI_W : 17;
  localparam int V_W       = 33;
  localparam int PROD_W    = V_W + MUL_B;
  localparam int ACC_W     = COEF_WIDTH + 35;
  localparam int TOP_W     = ACC_W - 31;

  // configuration registers
  logic signed [COEF_WIDTH-1:0] ff0_q, ff2_q, fb1_q, fb2_q;
  logic [15:0]                  attack_q, release_q;

  // filter and envelope state
  logic signed [SAMPLE_WIDTH-1:0] x_q, xd1_q, xd2_q;
  logic signed [31:0]             y_q, yd1_q, yd2_q;
  logic                           sat_q;
  logic [30:0]                    lvl_q, lvl_d;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  // sequencer
  bef_pkg::step_t  step_q, step_d;
  bef_pkg::uword_t uw;
  logic            stall, go;

  // output register
  logic        out_valid_q;
  logic [31:0] out_filt_q;
  logic [30:0] out_env_q;
  logic        out_sat_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q     <= '0;
      ff2_q     <= '0;
      fb1_q     <= '0;
      fb2_q     <= '0;
      attack_q  <= bef_pkg::ATTACK_RST;
      release_q <= bef_pkg::RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (bef_pkg::cfg_idx_e'(cfg_idx_i))
        bef_pkg::REG_FEED_ZERO: ff0_q     <= cfg_data_i;
        bef_pkg::REG_FEED_TWO:  ff2_q     <= cfg_data_i;
        bef_pkg::REG_BACK_ONE:  fb1_q     <= cfg_data_i;
        bef_pkg::REG_BACK_TWO:  fb2_q     <= cfg_data_i;
        bef_pkg::REG_ATTACK:    attack_q  <= cfg_data_i[15:0];
        bef_pkg::REG_RELEASE:   release_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control word fetch
  always_comb begin
    uw = bef_pkg::ucode_rom(step_q);
  end

  // next step: hold while the step's handshake is not met
  always_comb begin
    stall  = ((uw.wt == bef_pkg::WAIT_IN) && !s_axis_tvalid) ||
             ((uw.wt == bef_pkg::WAIT_OUT) && out_valid_q && !m_axis_tready);
    go     = !stall;
    step_d = go ? uw.nxt : step_q;
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (uw.wt == bef_pkg::WAIT_IN);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = {1'b0, out_env_q, out_filt_q};
    m_axis_tuser  = out_sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // sample alignment to Q8.24
  logic signed [V_W-1:0] x_in_al, x_al, x2_al;

  generate
    if (SAMPLE_WIDTH <= 25) begin : g_align_up
      assign x_in_al = V_W'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])) <<< (25 - SAMPLE_WIDTH);
      assign x_al    = V_W'(x_q) <<< (25 - SAMPLE_WIDTH);
      assign x2_al   = V_W'(xd2_q) <<< (25 - SAMPLE_WIDTH);
    end else begin : g_align_dn
      assign x_in_al = V_W'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]) >>> (SAMPLE_WIDTH - 25));
      assign x_al    = V_W'(x_q >>> (SAMPLE_WIDTH - 25));
      assign x2_al   = V_W'(xd2_q >>> (SAMPLE_WIDTH - 25));
    end
  endgenerate

  // multiplier operands
  logic signed [V_W-1:0]        mul_a;
  logic signed [COEF_WIDTH-1:0] coef_sel;
  logic signed [MUL_B-1:0]      mul_b;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      prod_ext;

  always_comb begin
    unique case (uw.coef)
      bef_pkg::COEF_FF0: coef_sel = ff0_q;
      bef_pkg::COEF_FF2: coef_sel = ff2_q;
      bef_pkg::COEF_FB1: coef_sel = fb1_q;
      bef_pkg::COEF_FB2: coef_sel = fb2_q;
      default:           coef_sel = ff0_q;
    endcase
  end

  always_comb begin
    unique case (uw.src)
      bef_pkg::SRC_IN:   mul_a = x_in_al;
      bef_pkg::SRC_X:    mul_a = x_al;
      bef_pkg::SRC_X2:   mul_a = x2_al;
      bef_pkg::SRC_YNEG: mul_a = (uw.coef == bef_pkg::COEF_FB1) ? -V_W'(yd1_q) : -V_W'(yd2_q);
      default:           mul_a = x_in_al;
    endcase
    // coefficient split: unsigned low half, signed high half
    if (uw.hi) begin
      mul_b = MUL_B'(signed'(coef_sel[COEF_WIDTH-1:16]));
    end else begin
      mul_b = signed'(MUL_B'({1'b0, coef_sel[15:0]}));
    end
    prod     = mul_a * mul_b;
    prod_ext = uw.hi ? (ACC_W'(prod) <<< 16) : ACC_W'(prod);
  end

  // saturation of the floored sum
  logic signed [ACC_W-1:0] acc_sh;
  logic [TOP_W-1:0]        acc_top;
  logic                    ovf;
  logic signed [31:0]      y_sat;

  always_comb begin
    acc_sh  = acc_q >>> COEF_FRAC;
    acc_top = acc_sh[ACC_W-1:31];
    ovf     = !((&acc_top) || !(|acc_top));
    if (ovf) begin
      y_sat = acc_sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      y_sat = acc_sh[31:0];
    end
  end

  // envelope update
  logic [31:0]        y_neg;
  logic [30:0]        mag;
  logic [15:0]        rate;
  logic signed [31:0] diff;
  logic signed [16:0] rate_s;
  logic signed [48:0] eprod;
  logic signed [48:0] estep;

  always_comb begin
    y_neg  = 32'(-y_q);
    if (!y_q[31]) begin
      mag = y_q[30:0];
    end else begin
      mag = y_neg[31] ? '1 : y_neg[30:0];
    end
    rate   = (mag > lvl_q) ? attack_q : release_q;
    diff   = signed'({1'b0, mag}) - signed'({1'b0, lvl_q});
    rate_s = signed'({1'b0, rate});
    eprod  = diff * rate_s;
    estep  = eprod >>> 16;
    lvl_d  = lvl_q + estep[30:0];
  end

  // accumulator
  always_comb begin
    acc_d = uw.clr ? prod_ext : (acc_q + prod_ext);
  end

  always_ff @(posedge clk_i) begin
    if (go && (uw.op == bef_pkg::OP_MAC)) begin
      acc_q <= acc_d;
    end
    if (go && (uw.wt == bef_pkg::WAIT_IN)) begin
      x_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // filter and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xd1_q <= '0;
      xd2_q <= '0;
      y_q   <= '0;
      yd1_q <= '0;
      yd2_q <= '0;
      sat_q <= 1'b0;
      lvl_q <= '0;
    end else if (go) begin
      if (uw.op == bef_pkg::OP_SAT) begin
        xd2_q <= xd1_q;
        xd1_q <= x_q;
        yd2_q <= yd1_q;
        yd1_q <= y_sat;
        y_q   <= y_sat;
        sat_q <= ovf;
      end
      if (uw.op == bef_pkg::OP_ENV) begin
        lvl_q <= lvl_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && (uw.op == bef_pkg::OP_ENV)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && (uw.op == bef_pkg::OP_ENV)) begin
      out_filt_q <= y_q;
      out_env_q  <= lvl_d;
      out_sat_q  <= sat_q;
    end
  end

endmodule

// ===== dv/bef_envelope_checker.sv =====
// bef_envelope_checker: predicts the bandpass output and envelope level of every
// accepted sample and compares them with the result beats of the core
// depends on bef_pkg
`timescale 1ns / 1ps

module bef_envelope_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bef_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // sample_in
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [63:0]                   m_axis_tdata,   // filtered, envelope, zero pad
  input  logic                          m_axis_tuser,   // saturated
  output int                            mismatch_cnt_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [31:0] filtered;
    logic [30:0] envelope;
    logic        saturated;
  } env_beat_t;

  localparam logic signed [95:0] SAT_POS = 96'sd2147483647;
  localparam logic signed [95:0] SAT_NEG = -96'sd2147483648;

  // register copies
  logic signed [31:0] w_ff0, w_ff2, w_fb1, w_fb2;
  logic [15:0]        rate_attack, rate_release;

  // filter and tracker state
  logic signed [23:0] x_dly1, x_dly2;
  logic signed [31:0] y_dly1, y_dly2;
  logic [30:0]        env_level;

  env_beat_t filter_env_q[$];
  int        mismatches;

  // one sample through the biquad and the envelope tracker, state updated
  function automatic env_beat_t bandpass_envelope_step(input logic signed [23:0] x_new);
    logic signed [95:0] acc;
    longint             xq0, xq2, mag, lvl, rate, delta;
    env_beat_t          r;
    // samples move from Q1.23 to Q8.24
    xq0 = x_new;
    xq0 = xq0 * 2;
    xq2 = x_dly2;
    xq2 = xq2 * 2;
    // exact sum of products, then floor down to Q8.24
    acc = xq0 * w_ff0 + xq2 * w_ff2 - y_dly1 * w_fb1 - y_dly2 * w_fb2;
    acc = acc >>> 28;
    r.saturated = 1'b0;
    if (acc > SAT_POS) begin
      acc = SAT_POS;
      r.saturated = 1'b1;
    end else if (acc < SAT_NEG) begin
      acc = SAT_NEG;
      r.saturated = 1'b1;
    end
    r.filtered = acc[31:0];
    x_dly2 = x_dly1;
    x_dly1 = x_new;
    y_dly2 = y_dly1;
    y_dly1 = acc[31:0];
    // magnitude, full-scale negative clips to the positive maximum
    mag = y_dly1;
    if (mag < 0) mag = -mag;
    if (mag > 64'sd2147483647) mag = 64'sd2147483647;
    lvl   = env_level;
    rate  = (mag > lvl) ? rate_attack : rate_release;
    delta = (mag - lvl) * rate;
    lvl   = lvl + (delta >>> 16);
    env_level  = lvl[30:0];
    r.envelope = env_level;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_ff0        = '0;
      w_ff2        = '0;
      w_fb1        = '0;
      w_fb2        = '0;
      rate_attack  = bef_pkg::ATTACK_RST;
      rate_release = bef_pkg::RELEASE_RST;
      x_dly1       = '0;
      x_dly2       = '0;
      y_dly1       = '0;
      y_dly2       = '0;
      env_level    = '0;
      mismatches   = 0;
      filter_env_q.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin : watch
      env_beat_t want, got;
      // result beat against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.filtered  = m_axis_tdata[31:0];
        got.envelope  = m_axis_tdata[62:32];
        got.saturated = m_axis_tuser;
        if (filter_env_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: filtered %0d envelope %0d sat %0b",
                     $signed(got.filtered), got.envelope, got.saturated);
        end else begin
          want = filter_env_q.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: filtered exp %0d got %0d, ",
                        "envelope exp %0d got %0d, sat exp %0b got %0b"},
                       $signed(want.filtered), $signed(got.filtered),
                       want.envelope, got.envelope, want.saturated, got.saturated);
          end
        end
      end
      // register writes, out-of-range indexes ignored
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bef_pkg::REG_FEED_ZERO: w_ff0 = cfg_data_i;
          bef_pkg::REG_FEED_TWO:  w_ff2 = cfg_data_i;
          bef_pkg::REG_BACK_ONE:  w_fb1 = cfg_data_i;
          bef_pkg::REG_BACK_TWO:  w_fb2 = cfg_data_i;
          bef_pkg::REG_ATTACK:    rate_attack = cfg_data_i[15:0];
          bef_pkg::REG_RELEASE:   rate_release = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // accepted sample beat
      if (s_axis_tvalid && s_axis_tready)
        filter_env_q.push_back(bandpass_envelope_step(s_axis_tdata));
      mismatch_cnt_o <= mismatches;
      pending_o      <= filter_env_q.size();
    end
  end

endmodule

// ===== dv/bandpass_envelope_follower_core_tb.sv =====
// bandpass_envelope_follower_core_tb: drives samples and register settings into
// the core, stalls the result side and reports the verdict
// depends on bef_pkg, bandpass_envelope_follower_core and bef_envelope_checker
`timescale 1ns / 1ps

module bandpass_envelope_follower_core_tb;

  // indexes past the register list, written to check they are ignored
  localparam logic [bef_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bef_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [23:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h80_0000;
  localparam logic [23:0] SAMPLE_ONE = 24'h00_0001;
  localparam logic [23:0] SAMPLE_NEG = 24'hFF_FFFF;

  // stable bandpass, Q4.28
  localparam logic [31:0] BP_B0 = 32'sd13421773;
  localparam logic [31:0] BP_B2 = -32'sd13421773;
  localparam logic [31:0] BP_A1 = -32'sd483183821;
  localparam logic [31:0] BP_A2 = 32'sd241591910;

  localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_STARVE} rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bef_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]                   cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [63:0]                   m_axis_tdata;
  logic                          m_axis_tuser;

  int       mismatches;
  int       pending;
  int       burst_left;
  int       rx_tick;
  rx_mode_e rx_mode;

  bandpass_envelope_follower_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bef_envelope_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side stalls, pattern redrawn whenever the low seven tick bits are zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_tick       <= 0;
      rx_mode       <= RX_OPEN;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick[6:0] == 7'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PULSE:  m_axis_tready <= (rx_tick[4:0] < 5'd6);
        RX_STARVE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  // one register write beat, write enable left high for a following write
  task automatic cfg_write(input logic [bef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_setup(input logic [31:0] b0, input logic [31:0] b2,
                            input logic [31:0] a1, input logic [31:0] a2,
                            input logic [31:0] atk, input logic [31:0] rel);
    cfg_write(bef_pkg::REG_FEED_ZERO, b0);
    cfg_write(bef_pkg::REG_FEED_TWO, b2);
    cfg_write(bef_pkg::REG_BACK_ONE, a1);
    cfg_write(bef_pkg::REG_BACK_TWO, a2);
    cfg_write(bef_pkg::REG_ATTACK, atk);
    cfg_write(bef_pkg::REG_RELEASE, rel);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sample beat, sent in bursts with random gaps between them
  task automatic push_sample(input logic [23:0] v);
    logic rdy;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // mostly full-range samples, some small ones around zero
  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    v = 24'($urandom);
    if ($urandom_range(0, 3) == 0) v = {{15{v[8]}}, v[8:0]};
    return v;
  endfunction

  task automatic run_random(input int n);
    repeat (n) push_sample(rand_sample());
  endtask

  // drop valid, let the count catch up with the last beat, then drain every result
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] r0, r1, r2, r3;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero coefficients keep output and level at zero
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    settle_idle();

    // stable bandpass with default-like rates, extremes then random
    load_setup(BP_B0, BP_B2, BP_A1, BP_A2, 32'd3277, 32'd1966);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    push_sample(SAMPLE_NEG);
    push_sample(SAMPLE_ONE);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MIN);
    run_random(100);
    settle_idle();

    // extreme coefficients blow up into saturation both ways,
    // full attack and a frozen release
    load_setup(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 32'd65535, 32'd0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    push_sample('0);
    push_sample('0);
    push_sample(SAMPLE_MIN);
    run_random(50);
    settle_idle();

    // fully random coefficients and rates
    load_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(90);
    settle_idle();

    // small random coefficients, frozen attack, full release,
    // junk in the upper rate bits and writes past the register list
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    load_setup({{5{r0[26]}}, r0[26:0]}, {{5{r1[26]}}, r1[26:0]},
               {{5{r2[26]}}, r2[26:0]}, {{5{r3[26]}}, r3[26:0]},
               {16'($urandom), 16'd0}, {16'($urandom), 16'd65535});
    run_random(80);
    settle_idle();

    // stable bandpass again with random rates
    load_setup(BP_B0, BP_B2, BP_A1, BP_A2, $urandom_range(0, 65535),
               $urandom_range(0, 65535));
    run_random(80);
    settle_idle();

    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
